### sv/assert_macros.svh
// Assertion macros for the PID controller RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pidct_pkg.sv
// Shared types, constants and fixed-point helpers for the PID controller.
// No dependencies; imported by pidct_div, the PID controller and its testbench.
package pidct_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned CFG_AW = 4;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam logic [CFG_AW-1:0] CFG_KP       = 4'd0;
  localparam logic [CFG_AW-1:0] CFG_KI       = 4'd1;
  localparam logic [CFG_AW-1:0] CFG_KD       = 4'd2;
  localparam logic [CFG_AW-1:0] CFG_INT_MIN  = 4'd3;
  localparam logic [CFG_AW-1:0] CFG_INT_MAX  = 4'd4;
  localparam logic [CFG_AW-1:0] CFG_DERIV    = 4'd5;
  localparam logic [CFG_AW-1:0] CFG_OUT_MIN  = 4'd6;
  localparam logic [CFG_AW-1:0] CFG_OUT_MAX  = 4'd7;

  typedef struct packed {
    logic busy;
    logic ovf;
  } div_stat_t;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (32'd0 - unsigned'(x)) : unsigned'(x);
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
    if (x[32] != x[31]) begin
      return x[32] ? Q_MIN : Q_MAX;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    if (!neg) begin
      return (mag > 64'h0000_0000_7FFF_FFFF) ? Q_MAX : mag[31:0];
    end
    return (mag >= 64'h0000_0000_8000_0000) ? Q_MIN : (32'd0 - mag[31:0]);
  endfunction

  function automatic logic signed [33:0] sx34(input logic signed [31:0] x);
    return $signed({{2{x[31]}}, x});
  endfunction

  function automatic logic signed [31:0] clamp34(input logic signed [33:0] x,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [33:0] y;
    y = x;
    if (y < sx34(lo)) y = sx34(lo);
    if (y > sx34(hi)) y = sx34(hi);
    return y[31:0];
  endfunction

endpackage

### sv/pid_controller_clamped_terms.sv
// Positional PID step in Q16.16 with clamped integral, derivative and output.
// Uses pidct_pkg, pidct_div and assert_macros.svh.
//
// Channel  Handshake            Payload
// cfg      cfg_valid/cfg_ready  cfg_addr, cfg_data
// s        s_tvalid/s_tready    s_tdata, s_tuser
// m        m_tvalid/m_tready    m_tdata
//
// A non-restart item steps through CHG, KP, KI, KD, LO, HI, INT, DIVW and SUM.
// The radix-4 derivative divider starts in KD and runs beside the last of five
// passes through the shared 32x32 multiplier. A restart item gives no result.
// Synchronous reset restores register defaults and clears integral and prior error.
// s_tready is high only in idle; a stalled result holds in m_tdata while the
// next transfer is taken, and the new result waits until the old one leaves.
`include "assert_macros.svh"

module pid_controller_clamped_terms (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_addr,
  input  logic [63:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // setpoint, feedback, time_step
  input  logic [0:0]   s_tuser,   // restart
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata    // control, p_term, i_term, d_term
);
  import pidct_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHG  = 4'd1;
  localparam logic [3:0] ST_KP   = 4'd2;
  localparam logic [3:0] ST_KI   = 4'd3;
  localparam logic [3:0] ST_KD   = 4'd4;
  localparam logic [3:0] ST_LO   = 4'd5;
  localparam logic [3:0] ST_HI   = 4'd6;
  localparam logic [3:0] ST_INT  = 4'd7;
  localparam logic [3:0] ST_DIVW = 4'd8;
  localparam logic [3:0] ST_SUM  = 4'd9;

  logic signed [31:0] kp, ki, kd, int_min, int_max, d_min, d_max, out_min, out_max;
  logic [3:0]         state;
  logic signed [31:0] acc, prior, err, chg, p_val, inc, itm, d_val, d_raw;
  logic               first;
  logic [31:0]        dt, lo_hi, mul_a, mul_b, div_q;
  logic [63:0]        prod, m1, hi_sum;
  logic               s1, sd, dz, div_start;
  logic signed [32:0] sp_diff, chg_diff;
  logic signed [33:0] int_sum, out_sum;
  div_stat_t          div_stat;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      kp      <= '0;
      ki      <= '0;
      kd      <= '0;
      int_min <= Q_MIN;
      int_max <= Q_MAX;
      d_min   <= Q_MIN;
      d_max   <= Q_MAX;
      out_min <= Q_MIN;
      out_max <= Q_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        CFG_KP:      kp      <= cfg_data[31:0];
        CFG_KI:      ki      <= cfg_data[31:0];
        CFG_KD:      kd      <= cfg_data[31:0];
        CFG_INT_MIN: int_min <= cfg_data[31:0];
        CFG_INT_MAX: int_max <= cfg_data[31:0];
        CFG_DERIV: begin
          d_min <= cfg_data[31:0];
          d_max <= cfg_data[63:32];
        end
        CFG_OUT_MIN: out_min <= cfg_data[31:0];
        CFG_OUT_MAX: out_max <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign sp_diff  = $signed({s_tdata[31], s_tdata[31:0]}) -
                    $signed({s_tdata[63], s_tdata[63:32]});
  assign chg_diff = $signed({err[31], err}) - $signed({prior[31], prior});
  assign hi_sum   = prod + {32'd0, lo_hi};
  assign int_sum  = sx34(acc) + sx34(inc);
  assign out_sum  = sx34(p_val) + sx34(itm) + sx34(d_val);
  assign div_start = (state == ST_KD);

  always_comb begin
    if (dz) begin
      d_raw = '0;
    end else if (div_stat.ovf) begin
      d_raw = sd ? Q_MIN : Q_MAX;
    end else begin
      d_raw = sat_mag(sd, {32'd0, div_q});
    end
  end

  always_comb begin
    case (state)
      ST_CHG: begin
        mul_a = mag32(kp);
        mul_b = mag32(err);
      end
      ST_KP: begin
        mul_a = mag32(ki);
        mul_b = mag32(err);
      end
      ST_KI: begin
        mul_a = mag32(kd);
        mul_b = mag32(chg);
      end
      ST_KD: begin
        mul_a = m1[31:0];
        mul_b = dt;
      end
      ST_LO: begin
        mul_a = m1[63:32];
        mul_b = dt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  pidct_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[62:0]),
    .divisor  (dt),
    .quot     (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      acc      <= '0;
      prior    <= '0;
      first    <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && state != ST_SUM) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser[0]) begin
              acc   <= '0;
              prior <= '0;
              first <= 1'b1;
            end else begin
              err   <= sat33(sp_diff);
              dt    <= s_tdata[95:64];
              state <= ST_CHG;
            end
          end
        end
        ST_CHG: begin
          chg   <= first ? '0 : sat33(chg_diff);
          prior <= err;
          first <= 1'b0;
          state <= ST_KP;
        end
        ST_KP: begin
          p_val <= sat_mag(kp[31] ^ err[31], {16'd0, prod[63:16]});
          state <= ST_KI;
        end
        ST_KI: begin
          m1    <= prod;
          s1    <= ki[31] ^ err[31];
          state <= ST_KD;
        end
        ST_KD: begin
          dz    <= (prod == 64'd0);
          sd    <= kd[31] ^ chg[31];
          state <= ST_LO;
        end
        ST_LO: begin
          lo_hi <= prod[63:32];
          state <= ST_HI;
        end
        ST_HI: begin
          inc   <= sat_mag(s1, {8'd0, hi_sum[63:8]});
          state <= ST_INT;
        end
        ST_INT: begin
          acc   <= clamp34(int_sum, int_min, int_max);
          itm   <= clamp34(int_sum, int_min, int_max);
          state <= ST_DIVW;
        end
        ST_DIVW: begin
          if (!div_stat.busy) begin
            d_val <= clamp34(sx34(d_raw), d_min, d_max);
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {d_val, itm, p_val, clamp34(out_sum, out_min, out_max)};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_item_starts, s_tvalid && s_tready && !s_tuser[0], state == ST_CHG, "no start")
  `ASSERT_IMPL(a_div_finished, state == ST_SUM, !div_stat.busy, "sum reached with divider busy")
  `ASSERT_IMPL(a_load_from_sum, $rose(m_tvalid), $past(state) == ST_SUM, "load outside sum")

endmodule

### sv/pidct_div.sv
// Radix-4 restoring divider: floor(dividend * 2^8 / divisor), 32-bit quotient.
// Flags overflow when the quotient needs more than 32 bits. Uses pidct_pkg.
module pidct_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [62:0]           dividend,
  input  logic [31:0]           divisor,
  output logic [31:0]           quot,
  output pidct_pkg::div_stat_t  stat
);
  import pidct_pkg::*;

  localparam int BITS_PER_CYCLE = 2;
  localparam int CYCLES = QW / BITS_PER_CYCLE;
  localparam int CW = $clog2(CYCLES);

  logic [31:0]   rem, shq, dvs;
  logic [31:0]   rem_next, shq_next;
  logic [32:0]   trial;
  logic [CW-1:0] cnt;
  logic          busy, ovf;

  always_comb begin
    rem_next = rem;
    shq_next = shq;
    trial    = '0;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      trial    = {rem_next, shq_next[31]};
      shq_next = {shq_next[30:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem_next    = 32'(trial - {1'b0, dvs});
        shq_next[0] = 1'b1;
      end else begin
        rem_next = trial[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(CYCLES - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[55:24];
      shq <= {dividend[23:0], 8'd0};
      dvs <= divisor;
      ovf <= (dividend[62:24] >= {7'd0, divisor});
      cnt <= '0;
    end else if (busy) begin
      rem <= rem_next;
      shq <= shq_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign quot = shq;
  assign stat = '{busy: busy, ovf: ovf};

endmodule

### sim/tb_pid_controller_clamped_terms.sv
// Self-checking testbench for pid_controller_clamped_terms: directed and random PID steps
// checked against an in-bench fixed-point model of the positional controller.
// Depends on pidct_pkg and the RTL of pid_controller_clamped_terms.
module tb_pid_controller_clamped_terms;
  timeunit 1ns;
  timeprecision 1ps;

  import pidct_pkg::*;

  localparam logic [CFG_AW-1:0] CFG_NONE = 4'd9;
  localparam logic [31:0] ONE_SEC = 32'h0100_0000;
  localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SAT_LO = -64'sh0000_0000_8000_0000;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEMS_PER_SETTING = 280;

  typedef struct {
    logic        restart;
    logic [31:0] setpoint;
    logic [31:0] feedback;
    logic [31:0] time_step;
    bit          drain;
  } pid_sample_t;

  typedef struct packed {
    logic [31:0] d_term;
    logic [31:0] i_term;
    logic [31:0] p_term;
    logic [31:0] control;
  } pid_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_addr = '0;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;   // setpoint, feedback, time_step
  logic [0:0]   s_tuser = '0;   // restart
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;        // control, p_term, i_term, d_term

  pid_sample_t sample_q[$];
  pid_result_t result_q[$];
  int          queued = 0;
  int          errors = 0;
  int          send_gap_pct = 37;
  int          recv_gap_pct = 57;
  int          quiet_cycles = 0;
  bit          s_hs = 1'b0;

  logic signed [31:0] kp_q = '0;
  logic signed [31:0] ki_q = '0;
  logic signed [31:0] kd_q = '0;
  logic signed [31:0] imin_q = Q_MIN;
  logic signed [31:0] imax_q = Q_MAX;
  logic signed [31:0] dmin_q = Q_MIN;
  logic signed [31:0] dmax_q = Q_MAX;
  logic signed [31:0] omin_q = Q_MIN;
  logic signed [31:0] omax_q = Q_MAX;
  logic signed [31:0] integral_q = '0;
  logic signed [31:0] prior_err_q = '0;
  bit                 first_step_q = 1'b1;

  pid_controller_clamped_terms dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic longint sat_q(input longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  function automatic longint sat_mag_q(input bit neg, input logic [127:0] mag);
    if (!neg) return (mag > 128'h7FFF_FFFF) ? SAT_HI : $signed({32'd0, mag[31:0]});
    return (mag >= 128'h8000_0000) ? SAT_LO : -$signed({32'd0, mag[31:0]});
  endfunction

  function automatic logic [127:0] mag_q(input longint a);
    return {64'd0, (a < 0) ? -a : a};
  endfunction

  function automatic longint clamp_q(input longint x, input logic signed [31:0] lo,
                                     input logic signed [31:0] hi);
    if (x < longint'(lo)) x = longint'(lo);
    if (x > longint'(hi)) x = longint'(hi);
    return x;
  endfunction

  // a * dt >> 40, toward zero
  function automatic longint scale_dt(input longint a, input logic [31:0] dt);
    return sat_mag_q(a < 0, (mag_q(a) * {96'd0, dt}) >> 40);
  endfunction

  // a * 2^8 / dt, toward zero; a zero step saturates to the sign
  function automatic longint divide_dt(input longint a, input logic [31:0] dt);
    if (a == 0) return 0;
    if (dt == 0) return (a < 0) ? SAT_LO : SAT_HI;
    return sat_mag_q(a < 0, (mag_q(a) << 8) / {96'd0, dt});
  endfunction

  task automatic load_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
    case (idx)
      CFG_KP:      kp_q = val[31:0];
      CFG_KI:      ki_q = val[31:0];
      CFG_KD:      kd_q = val[31:0];
      CFG_INT_MIN: imin_q = val[31:0];
      CFG_INT_MAX: imax_q = val[31:0];
      CFG_DERIV: begin
        dmin_q = val[31:0];
        dmax_q = val[63:32];
      end
      CFG_OUT_MIN: omin_q = val[31:0];
      CFG_OUT_MAX: omax_q = val[31:0];
      default: ;
    endcase
  endtask

  task automatic pid_step(input logic restart, input logic [95:0] data);
    longint      err, p, itm, chg, dv, u;
    logic [31:0] dt;
    pid_result_t want;
    if (restart) begin
      integral_q = '0;
      prior_err_q = '0;
      first_step_q = 1'b1;
    end else begin
      dt = data[95:64];
      err = sat_q(longint'($signed(data[31:0])) - longint'($signed(data[63:32])));
      p = longint'(kp_q) * err;
      p = sat_mag_q(p < 0, mag_q(p) >> 16);
      itm = clamp_q(longint'(integral_q) + scale_dt(longint'(ki_q) * err, dt),
                    imin_q, imax_q);
      integral_q = itm[31:0];
      if (first_step_q) begin
        prior_err_q = err[31:0];
        first_step_q = 1'b0;
      end
      chg = sat_q(err - longint'(prior_err_q));
      dv = clamp_q(divide_dt(longint'(kd_q) * chg, dt), dmin_q, dmax_q);
      prior_err_q = err[31:0];
      u = clamp_q(p + itm + dv, omin_q, omax_q);
      want.control = u[31:0];
      want.p_term = p[31:0];
      want.i_term = itm[31:0];
      want.d_term = dv[31:0];
      result_q.push_back(want);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name,
               $signed(want), $signed(got));
      errors++;
    end
  endtask

  function automatic void add_sample(input logic restart, input logic [31:0] sp,
                                     input logic [31:0] fb, input logic [31:0] dt);
    pid_sample_t s;
    s.restart = restart;
    s.setpoint = sp;
    s.feedback = fb;
    s.time_step = dt;
    s.drain = (queued % 97 == 96);
    sample_q.push_back(s);
    queued++;
  endfunction

  function automatic logic [31:0] rand_q16();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(32'h00FF_FFFF);
      2: v = $urandom_range(1) ? Q_MAX : Q_MIN;
      default: v = $urandom_range(32'h0004_0000);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic logic [31:0] rand_dt();
    case ($urandom_range(3))
      0: return $urandom_range(32'hFFFF_FFFF, 1);
      1: return $urandom_range(32'h0200_0000, 32'h0000_4000);
      2: return $urandom_range(255, 1);
      default: return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    logic [31:0] g;
    case ($urandom_range(3))
      0: g = $urandom;
      1: g = $urandom_range(32'h0008_0000);
      2: g = $urandom_range(1) ? Q_MAX : Q_MIN;
      default: g = $urandom_range(32'h0001_0000);
    endcase
    if ($urandom_range(1)) g = -g;
    return g;
  endfunction

  // {max, min}
  function automatic logic [63:0] rand_limits();
    logic [31:0] a, b;
    a = $urandom_range(32'h0400_0000);
    b = $urandom_range(32'h0400_0000);
    case ($urandom_range(3))
      0: return {Q_MAX, Q_MIN};
      1: return {b, -a};
      2: return {-a - 32'd1, a};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // mostly restart then a run around a slowly drifting setpoint, with some noise
  function automatic void add_run();
    logic [31:0] sp;
    int          len;
    sp = rand_q16();
    len = $urandom_range(30, 4);
    if ($urandom_range(9) < 8) add_sample(1'b1, $urandom, $urandom, $urandom);
    repeat (len) begin
      if ($urandom_range(99) < 3) begin
        add_sample(1'b1, $urandom, $urandom, $urandom);
      end else if ($urandom_range(9) == 0) begin
        add_sample(1'b0, rand_q16(), rand_q16(), rand_dt());
      end else begin
        add_sample(1'b0, sp, sp + $urandom_range(32'h0010_0000) - 32'h0008_0000,
                   rand_dt());
      end
      if ($urandom_range(7) == 0) sp = sp + $urandom_range(32'h0004_0000) - 32'h0002_0000;
    end
  endfunction

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_32(input logic [CFG_AW-1:0] idx, input logic [31:0] val);
    write_reg(idx, {32'($urandom), val});
  endtask

  task automatic settle();
    while (sample_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(negedge clk) begin : drv
    pid_sample_t nxt;
    if (!rst && (!s_tvalid || s_hs)) begin
      if (sample_q.size() != 0 && !(sample_q[0].drain && result_q.size() != 0) &&
          $urandom_range(99) >= send_gap_pct) begin
        nxt = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {nxt.time_step, nxt.feedback, nxt.setpoint};
        s_tuser <= nxt.restart;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  always @(posedge clk) begin : mon
    pid_result_t got, want;
    s_hs = s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) load_reg(cfg_addr, cfg_data);
      if (s_hs) pid_step(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (result_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("control", want.control, got.control);
          check_field("p_term", want.p_term, got.p_term);
          check_field("i_term", want.i_term, got.i_term);
          check_field("d_term", want.d_term, got.d_term);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout: no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : seq
    logic [63:0] lim;
    int          stop;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // moderate gains and limits
    write_32(CFG_KP, 32'h0001_0000);
    write_32(CFG_KI, 32'h0000_8000);
    write_32(CFG_KD, 32'h0000_4000);
    write_32(CFG_INT_MIN, 32'hFF9C_0000);
    write_32(CFG_INT_MAX, 32'h0064_0000);
    write_reg(CFG_DERIV, 64'h0032_0000_FFCE_0000);
    write_32(CFG_OUT_MIN, 32'hFF38_0000);
    write_32(CFG_OUT_MAX, 32'h00C8_0000);
    add_sample(1'b1, $urandom, $urandom, $urandom);
    add_sample(1'b0, 32'd0, 32'd0, ONE_SEC);
    add_sample(1'b0, Q_MAX, Q_MIN, ONE_SEC);
    add_sample(1'b0, Q_MIN, Q_MAX, 32'hFFFF_FFFF);
    add_sample(1'b0, 32'h0001_0000, 32'd0, 32'd0);
    add_sample(1'b0, 32'h0001_0000, 32'd0, 32'd0);
    add_sample(1'b0, 32'hFFFF_0000, 32'd0, 32'd0);
    add_sample(1'b0, 32'h0003_0000, 32'h0001_0000, 32'd1);
    add_sample(1'b0, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_FFFF);
    add_sample(1'b1, 32'd0, 32'd0, 32'd0);
    add_sample(1'b0, 32'h0100_0000, 32'hFF00_0000, 32'h0010_0000);
    add_sample(1'b0, Q_MAX, Q_MAX, ONE_SEC);
    settle();

    // extreme gains, inverted integral clamp
    write_32(CFG_KP, Q_MAX);
    write_32(CFG_KI, Q_MIN);
    write_32(CFG_KD, Q_MIN);
    write_32(CFG_INT_MIN, 32'h000A_0000);
    write_32(CFG_INT_MAX, 32'hFFF6_0000);
    write_reg(CFG_DERIV, {Q_MAX, Q_MIN});
    write_32(CFG_OUT_MIN, Q_MIN);
    write_32(CFG_OUT_MAX, Q_MAX);
    add_sample(1'b1, $urandom, $urandom, $urandom);
    add_sample(1'b0, Q_MAX, Q_MIN, 32'hFFFF_FFFF);
    add_sample(1'b0, Q_MIN, Q_MAX, 32'd1);
    add_sample(1'b0, Q_MAX, 32'd0, 32'd0);
    add_sample(1'b0, 32'd0, Q_MAX, 32'd0);
    add_sample(1'b0, 32'h0001_0000, 32'h0002_0000, ONE_SEC);
    settle();

    // inverted derivative and output clamps; unmapped index must not land anywhere
    write_reg(CFG_DERIV, 64'hFFFB_0000_0005_0000);
    write_32(CFG_OUT_MIN, 32'h0001_0000);
    write_32(CFG_OUT_MAX, 32'hFFFF_0000);
    write_reg(CFG_NONE, {32'($urandom), 32'($urandom)});
    add_sample(1'b0, 32'h0004_0000, 32'h0001_0000, ONE_SEC);
    add_sample(1'b0, Q_MIN, Q_MAX, 32'd3);
    add_sample(1'b0, 32'($urandom), 32'($urandom), ONE_SEC);

    for (int s = 0; s < 6; s++) begin
      settle();
      if (s < 2) begin
        send_gap_pct = 37;
        recv_gap_pct = 57;
      end else if (s < 4) begin
        send_gap_pct = 57;
        recv_gap_pct = 37;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      write_32(CFG_KP, rand_gain());
      write_32(CFG_KI, rand_gain());
      write_32(CFG_KD, rand_gain());
      lim = (s == 5) ? {Q_MAX, Q_MIN} : rand_limits();
      write_32(CFG_INT_MIN, lim[31:0]);
      write_32(CFG_INT_MAX, lim[63:32]);
      write_reg(CFG_DERIV, (s == 5) ? {Q_MAX, Q_MIN} : rand_limits());
      lim = (s == 5) ? {Q_MAX, Q_MIN} : rand_limits();
      write_32(CFG_OUT_MIN, lim[31:0]);
      write_32(CFG_OUT_MAX, lim[63:32]);
      stop = queued + ITEMS_PER_SETTING;
      while (queued < stop) add_run();
    end

    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
